>>> sv/status_led_pattern_generator_macros.svh
// ---------------------------------------------------------------------------
// Status LED pattern generator assertion macros
// Shared helpers for concurrent checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef STATUS_LED_PATTERN_GENERATOR_MACROS_SVH
`define STATUS_LED_PATTERN_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// Check that a condition holds at every clock edge outside reset
`define SLPG_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle
`define SLPG_ASSERT_NEXT(lbl, trig, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cons)) \
      else $error(msg);

`else

`define SLPG_ASSERT_ALWAYS(lbl, cond, msg)
`define SLPG_ASSERT_NEXT(lbl, trig, cons, msg)

`endif

`endif

>>> sv/slpg_pkg.sv
// ---------------------------------------------------------------------------
// Status LED pattern generator package
// Request codes, pattern codes, register map and shared structures.
// ---------------------------------------------------------------------------
`default_nettype none

package slpg_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned PHASE_W  = 4;
   localparam int unsigned CSR_IDX_W = 3;

   // Request kinds
   typedef enum logic [1:0] {
      CMD_FLIGHT_MODE = 2'd0,
      CMD_CALIBRATION = 2'd1,
      CMD_GESTURE     = 2'd2,
      CMD_TICK        = 2'd3
   } cmd_type;

   // Flight modes
   localparam logic [1:0] MODE_SETUP     = 2'd0;
   localparam logic [1:0] MODE_ARMED     = 2'd1;
   localparam logic [1:0] MODE_IN_FLIGHT = 2'd2;

   // Calibration status
   localparam logic [1:0] CAL_IDLE        = 2'd0;
   localparam logic [1:0] CAL_SUCCESS     = 2'd1;
   localparam logic [1:0] CAL_ERROR       = 2'd2;
   localparam logic [1:0] CAL_IN_PROGRESS = 2'd3;

   // Hall gestures
   localparam logic [1:0] GEST_OTHER  = 2'd0;
   localparam logic [1:0] GEST_CLICK  = 2'd1;
   localparam logic [1:0] GEST_DOUBLE = 2'd2;

   // LED patterns
   typedef enum logic [2:0] {
      PAT_OFF    = 3'd0,
      PAT_SLOW   = 3'd1,
      PAT_HEART  = 3'd2,
      PAT_STEADY = 3'd3,
      PAT_FAST   = 3'd4,
      PAT_RAPID  = 3'd5
   } pattern_type;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_HALF   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEART_STEP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_HALF   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAPID_HALF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CLICK_EXT   = 3'd4;

   // Register reset values
   localparam logic [PERIOD_W-1:0] SLOW_HALF_RST  = 16'd500;
   localparam logic [PERIOD_W-1:0] HEART_STEP_RST = 16'd100;
   localparam logic [PERIOD_W-1:0] FAST_HALF_RST  = 16'd100;
   localparam logic [PERIOD_W-1:0] RAPID_HALF_RST = 16'd50;
   localparam logic [PERIOD_W-1:0] CLICK_EXT_RST  = 16'd100;

   typedef struct packed {
      logic [PERIOD_W-1:0] slow_half_period;
      logic [PERIOD_W-1:0] heartbeat_step;
      logic [PERIOD_W-1:0] fast_half_period;
      logic [PERIOD_W-1:0] rapid_half_period;
      logic [PERIOD_W-1:0] click_extend;
   } cfg_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [1:0]        flight_mode;
      logic [1:0]        cal_status;
      logic [1:0]        gesture;
      logic [TIME_W-1:0] now_ms;
   } request_type;

   typedef struct packed {
      pattern_type       base_pattern;
      logic              calibrating;
      logic              error_seen;
      logic [TIME_W-1:0] last_toggle_ms;
      logic [PHASE_W-1:0] heartbeat_phase;
      logic              led_level;
   } led_state_type;

endpackage

`default_nettype wire

>>> sv/slpg_csr.sv
// ---------------------------------------------------------------------------
// Status LED pattern generator configuration registers
// Holds the five timing registers, written through a plain write port.
// ---------------------------------------------------------------------------
`default_nettype none

module slpg_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_we,
   input  wire logic [slpg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [slpg_pkg::PERIOD_W-1:0]  csr_wdata,
   output slpg_pkg::cfg_type                   cfg
);
   import slpg_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; unknown indexes change nothing
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SLOW_HALF:  cfg_in.slow_half_period  = csr_wdata;
            CSR_HEART_STEP: cfg_in.heartbeat_step    = csr_wdata;
            CSR_FAST_HALF:  cfg_in.fast_half_period  = csr_wdata;
            CSR_RAPID_HALF: cfg_in.rapid_half_period = csr_wdata;
            CSR_CLICK_EXT:  cfg_in.click_extend      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_half_period  <= SLOW_HALF_RST;
         cfg_ff.heartbeat_step    <= HEART_STEP_RST;
         cfg_ff.fast_half_period  <= FAST_HALF_RST;
         cfg_ff.rapid_half_period <= RAPID_HALF_RST;
         cfg_ff.click_extend      <= CLICK_EXT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> sv/slpg_step.sv
// ---------------------------------------------------------------------------
// Status LED pattern generator update logic
// Computes the next LED state from the current state and one request.
// ---------------------------------------------------------------------------
`default_nettype none

module slpg_step #(
   parameter int unsigned HEARTBEAT_PHASES = 10
) (
   input  wire slpg_pkg::cfg_type       cfg,
   input  wire slpg_pkg::request_type   req,
   input  wire slpg_pkg::led_state_type cur,
   output      slpg_pkg::led_state_type nxt
);
   import slpg_pkg::*;

   localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(HEARTBEAT_PHASES - 1);
   localparam logic [PHASE_W-1:0] PHASE_ZERO = '0;
   localparam logic [PHASE_W-1:0] PHASE_TWO  = PHASE_W'(2);

   pattern_type         active;
   logic [PERIOD_W-1:0] period;
   logic [TIME_W-1:0]   elapsed;
   logic                due;
   logic [PHASE_W-1:0]  phase_next;

   // Pick the active pattern: error over calibrating over base
   always_comb begin
      if (cur.error_seen) begin
         active = PAT_RAPID;
      end else if (cur.calibrating) begin
         active = PAT_FAST;
      end else begin
         active = cur.base_pattern;
      end
   end

   // Select the period of the active pattern
   always_comb begin
      case (active)
         PAT_SLOW:  period = cfg.slow_half_period;
         PAT_HEART: period = cfg.heartbeat_step;
         PAT_FAST:  period = cfg.fast_half_period;
         PAT_RAPID: period = cfg.rapid_half_period;
         default:   period = '0;
      endcase
   end

   // Step is due when the signed elapsed time is non-negative and reaches the period
   assign elapsed = req.now_ms - cur.last_toggle_ms;
   assign due     = !elapsed[TIME_W-1] && (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period});

   assign phase_next = (cur.heartbeat_phase == LAST_PHASE) ? PHASE_ZERO
                                                            : cur.heartbeat_phase + 1'b1;

   // Apply the request
   always_comb begin
      nxt = cur;
      unique case (req.cmd)
         CMD_FLIGHT_MODE: begin
            case (req.flight_mode)
               MODE_SETUP:     nxt.base_pattern = PAT_SLOW;
               MODE_ARMED:     nxt.base_pattern = PAT_HEART;
               MODE_IN_FLIGHT: nxt.base_pattern = PAT_STEADY;
               default: ;
            endcase
         end
         CMD_CALIBRATION: begin
            nxt.calibrating = (req.cal_status == CAL_IN_PROGRESS);
            if (req.cal_status == CAL_ERROR) begin
               nxt.error_seen = 1'b1;
            end
         end
         CMD_GESTURE: begin
            if (req.gesture == GEST_CLICK || req.gesture == GEST_DOUBLE) begin
               nxt.led_level      = 1'b1;
               nxt.last_toggle_ms = req.now_ms
                                  + {{(TIME_W-PERIOD_W){1'b0}}, cfg.click_extend};
            end
         end
         CMD_TICK: begin
            case (active) inside
               PAT_SLOW, PAT_FAST, PAT_RAPID: begin
                  if (due) begin
                     nxt.last_toggle_ms = req.now_ms;
                     nxt.led_level      = !cur.led_level;
                  end
               end
               PAT_HEART: begin
                  if (due) begin
                     nxt.last_toggle_ms  = req.now_ms;
                     nxt.heartbeat_phase = phase_next;
                     nxt.led_level       = (phase_next == PHASE_ZERO)
                                        || (phase_next == PHASE_TWO);
                  end
               end
               PAT_STEADY: nxt.led_level = 1'b1;
               default:    nxt.led_level = 1'b0;
            endcase
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

>>> sv/status_led_pattern_generator.sv
// ---------------------------------------------------------------------------
// Status LED pattern generator
// Drives one status LED from flight-mode, calibration, gesture and tick
// requests, one LED level per request.
// ---------------------------------------------------------------------------
// A request is taken into an input register; the state update then runs in
// one pass as the request moves into the state register and result slot, and
// the new LED level appears on rsp_led_on with rsp_valid high. One request
// can be accepted every cycle while the result is not stalled. rsp_stall
// holds the result and, once the input register is also full, raises
// req_stall.
// The user must write configuration registers through
// csr_we/csr_index/csr_wdata only while no request is in flight; the block
// itself does not enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

`include "status_led_pattern_generator_macros.svh"

module status_led_pattern_generator #(
   parameter int unsigned HEARTBEAT_PHASES = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output      logic                           req_stall,
   input  wire logic [1:0]                     req_cmd,
   input  wire logic [1:0]                     req_flight_mode,
   input  wire logic [1:0]                     req_cal_status,
   input  wire logic [1:0]                     req_gesture,
   input  wire logic [slpg_pkg::TIME_W-1:0]    req_now_ms,
   // result channel
   output      logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   output      logic                           rsp_led_on,
   // configuration port
   input  wire logic                           csr_we,
   input  wire logic [slpg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [slpg_pkg::PERIOD_W-1:0]  csr_wdata
);
   import slpg_pkg::*;

   cfg_type       cfg;
   request_type   req_ff;
   request_type   req_in;
   logic          req_valid_ff;
   logic          req_valid_in;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   led_state_type state_ff;
   led_state_type state_in;
   led_state_type state_upd;
   logic          advance;
   logic          move;

   slpg_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slpg_step #(
      .HEARTBEAT_PHASES (HEARTBEAT_PHASES)
   ) u_step (
      .cfg (cfg),
      .req (req_ff),
      .cur (state_ff),
      .nxt (state_upd)
   );

   // Flow control: the result slot frees when empty or taken
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign move      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;

   // Load the input register whenever it is not held
   always_comb begin
      req_in.cmd         = cmd_type'(req_cmd);
      req_in.flight_mode = req_flight_mode;
      req_in.cal_status  = req_cal_status;
      req_in.gesture     = req_gesture;
      req_in.now_ms      = req_now_ms;
      req_valid_in       = req_stall ? req_valid_ff : req_valid;
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_ff <= req_in;
      end
   end

   // Commit the state update as the request moves into the result slot
   always_comb begin
      state_in     = move ? state_upd : state_ff;
      rsp_valid_in = advance ? req_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff            <= 1'b0;
         rsp_valid_ff            <= 1'b0;
         state_ff.base_pattern    <= PAT_OFF;
         state_ff.calibrating     <= 1'b0;
         state_ff.error_seen      <= 1'b0;
         state_ff.last_toggle_ms  <= '0;
         state_ff.heartbeat_phase <= '0;
         state_ff.led_level       <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_led_on = state_ff.led_level;

   // Checks
   `SLPG_ASSERT_NEXT(a_error_sticky, state_ff.error_seen, state_ff.error_seen,
      "error flag cleared")
   `SLPG_ASSERT_ALWAYS(a_phase_range,
      state_ff.heartbeat_phase < PHASE_W'(HEARTBEAT_PHASES), "heartbeat phase out of range")
   `SLPG_ASSERT_NEXT(a_state_hold, rsp_valid_ff && rsp_stall, $stable(state_ff),
      "state moved under a stalled result")
   `SLPG_ASSERT_NEXT(a_steady_on,
      move && req_ff.cmd == CMD_TICK && !state_ff.error_seen && !state_ff.calibrating
         && state_ff.base_pattern == PAT_STEADY,
      state_ff.led_level, "steady pattern left LED dark")

endmodule

`default_nettype wire
